@@ hdl/lgld_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Life generation block with loop detection.
// Shared constants, controller states and the command and status structs.
package lgld_pkg;

  localparam int MAX_ROW_WORDS_DEF = 32;
  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int MAX_ROWS_DEF      = 1024;

  localparam logic [10:0] WIDTH_RESET    = 11'd300;
  localparam logic [10:0] HEIGHT_RESET   = 11'd300;
  localparam logic [15:0] PATIENCE_RESET = 16'd100;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_PATIENCE = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL,
    S_EDGE,
    S_FLSTART,
    S_FLRD,
    S_FLCOL,
    S_FEDGE,
    S_CRC,
    S_HIST,
    S_PUT
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       col;
    logic       fl_start;
    logic       fl_read;
    logic       fl_shift;
    logic       flush;
    logic       emit;
    logic       edge_mode;
    logic       crc_step;
    logic [1:0] crc_byte;
    logic       hist;
    logic       put;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic row_ge1;
    logic last_col;
    logic last_row;
    logic fl_j_ge1;
    logic fl_last;
    logic fl_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/life_generation_with_loop_detect.sv @@
`timescale 1ns / 1ps
// Life generation step with CRC loop detection, top level.
// Depends on lgld_pkg, lgld_ctrl, lgld_dp.
//
// Usage: one generation enters as 32-cell words in raster order on
// in_valid_i / in_stall_o / cell_word_i. Next-generation words leave one
// row behind on out_valid_o / out_stall_i with row and column; the final
// word of a generation carries gen_last_o, the generation CRC-16/ARC, the
// history hit flag and the restart request.
// Configuration (width, height, patience) is written through cfg_valid_i /
// cfg_ready_o / cfg_index_i / cfg_data_i; the user must do so only while idle,
// which the block itself does not enforce. cfg_ready_o is always high.
// Sequencing: a word emitted in the column step passes four CRC byte steps
// through the shared CRC unit and the output load; the right-edge word adds
// its own window compute, the last word of a generation a history compare.
// The final row of a frame is flushed from the row RAMs after a start step,
// with a read and a column step per word plus the emission steps.
// One word is worked on at a time.
// Reset clears counters, CRC and history and reloads patience; row RAMs need no clear.
// While the receiver stalls, the finished word waits in the output register
// and the sequencer holds before loading the next one.
module life_generation_with_loop_detect
  import lgld_pkg::*;
#(
  parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] cell_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_word_o,
  output logic [9:0]  out_row_o,
  output logic [4:0]  out_col_o,
  output logic        gen_last_o,
  output logic [15:0] gen_crc_o,
  output logic        loop_hit_o,
  output logic        restart_request_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lgld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  lgld_dp #(
    .MAX_ROW_WORDS (MAX_ROW_WORDS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_ROWS      (MAX_ROWS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cell_word_i       (cell_word_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .next_word_o       (next_word_o),
    .out_row_o         (out_row_o),
    .out_col_o         (out_col_o),
    .gen_last_o        (gen_last_o),
    .gen_crc_o         (gen_crc_o),
    .loop_hit_o        (loop_hit_o),
    .restart_request_o (restart_request_o)
  );

endmodule

@@ hdl/lgld_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lgld_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the Life block: steps each input word through its emissions.
// Depends on lgld_pkg.
module lgld_ctrl
  import lgld_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     in_stall_o
);

  state_e     state_q, state_d, resume;
  logic       edge_pend_q, edge_pend_d;
  logic       flush_pend_q, flush_pend_d;
  logic       in_flush_q, in_flush_d;
  logic       last_q, last_d;
  logic [1:0] cnt_q, cnt_d;
  logic       edge_now, flush_now;

  assign edge_now  = stat_i.last_col && stat_i.row_ge1;
  assign flush_now = stat_i.last_col && stat_i.last_row;

  always_comb begin
    priority if (edge_pend_q) begin
      resume = S_EDGE;
    end else if (flush_pend_q) begin
      resume = S_FLSTART;
    end else if (in_flush_q) begin
      resume = stat_i.fl_done ? S_FEDGE : S_FLRD;
    end else begin
      resume = S_IDLE;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_COL;
      S_COL: begin
        priority if (stat_i.emit_ok) state_d = S_CRC;
        else if (edge_now)           state_d = S_EDGE;
        else if (flush_now)          state_d = S_FLSTART;
        else                         state_d = S_IDLE;
      end
      S_EDGE:    state_d = S_CRC;
      S_FLSTART: state_d = S_FLRD;
      S_FLRD:    state_d = S_FLCOL;
      S_FLCOL: begin
        priority if (stat_i.fl_j_ge1) state_d = S_CRC;
        else if (stat_i.fl_last)      state_d = S_FEDGE;
        else                          state_d = S_FLRD;
      end
      S_FEDGE:   state_d = S_CRC;
      S_CRC:     if (cnt_q == 2'd3) state_d = last_q ? S_HIST : S_PUT;
      S_HIST:    state_d = S_PUT;
      S_PUT:     if (stat_i.out_free) state_d = resume;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    edge_pend_d  = edge_pend_q;
    flush_pend_d = flush_pend_q;
    in_flush_d   = in_flush_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    in_stall_o   = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE:    cmd_o.accept = in_valid_i;
      S_COL: begin
        cmd_o.col    = 1'b1;
        cmd_o.emit   = stat_i.emit_ok;
        edge_pend_d  = edge_now;
        flush_pend_d = flush_now;
      end
      S_EDGE: begin
        cmd_o.emit      = 1'b1;
        cmd_o.edge_mode = 1'b1;
        edge_pend_d     = 1'b0;
      end
      S_FLSTART: begin
        cmd_o.fl_start = 1'b1;
        flush_pend_d   = 1'b0;
        in_flush_d     = 1'b1;
      end
      S_FLRD:    cmd_o.fl_read = 1'b1;
      S_FLCOL: begin
        cmd_o.fl_shift = 1'b1;
        cmd_o.flush    = 1'b1;
        cmd_o.emit     = stat_i.fl_j_ge1;
      end
      S_FEDGE: begin
        cmd_o.emit      = 1'b1;
        cmd_o.edge_mode = 1'b1;
        cmd_o.flush     = 1'b1;
        last_d          = 1'b1;
        in_flush_d      = 1'b0;
      end
      S_CRC: begin
        cmd_o.crc_step = 1'b1;
        cmd_o.crc_byte = cnt_q;
        cnt_d          = cnt_q + 2'd1;
      end
      S_HIST:    cmd_o.hist = 1'b1;
      S_PUT: begin
        cmd_o.put  = stat_i.out_free;
        cmd_o.last = last_q;
        if (stat_i.out_free) last_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      edge_pend_q  <= 1'b0;
      flush_pend_q <= 1'b0;
      in_flush_q   <= 1'b0;
      last_q       <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      state_q      <= state_d;
      edge_pend_q  <= edge_pend_d;
      flush_pend_q <= flush_pend_d;
      in_flush_q   <= in_flush_d;
      last_q       <= last_d;
      cnt_q        <= cnt_d;
    end
  end

endmodule

@@ hdl/lgld_dp.sv @@
`timescale 1ns / 1ps
// Datapath: config registers, three rotating row RAMs, column window, Life
// rule, CRC, history and output register. Depends on lgld_pkg, lgld_ram.
module lgld_dp
  import lgld_pkg::*;
#(
  parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [31:0] cell_word_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [31:0] next_word_o,
  output logic [9:0]  out_row_o,
  output logic [4:0]  out_col_o,
  output logic        gen_last_o,
  output logic [15:0] gen_crc_o,
  output logic        loop_hit_o,
  output logic        restart_request_o
);

  localparam int CW   = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MAXW = MAX_ROW_WORDS * 32;
  localparam int WB0  = $clog2(MAXW + 32);
  localparam int WB   = (WB0 > 11) ? WB0 : 12;
  localparam int HB0  = $clog2(MAX_ROWS + 1);
  localparam int HB   = (HB0 > 11) ? HB0 : 12;

  typedef struct packed {
    logic [31:0] up;
    logic [31:0] mid;
    logic [31:0] dn;
  } col3_t;

  function automatic logic [31:0] life_fn(col3_t l, col3_t m, col3_t r);
    logic [31:0] nb [8];
    logic [31:0] res;
    logic [3:0]  n;
    nb[0] = (m.up << 1) | {31'd0, l.up[31]};
    nb[1] = m.up;
    nb[2] = (m.up >> 1) | {r.up[0], 31'd0};
    nb[3] = (m.mid << 1) | {31'd0, l.mid[31]};
    nb[4] = (m.mid >> 1) | {r.mid[0], 31'd0};
    nb[5] = (m.dn << 1) | {31'd0, l.dn[31]};
    nb[6] = m.dn;
    nb[7] = (m.dn >> 1) | {r.dn[0], 31'd0};
    res = '0;
    for (int i = 0; i < 32; i++) begin
      n = '0;
      for (int k = 0; k < 8; k++) n = n + {3'd0, nb[k][i]};
      res[i] = (n == 4'd3) || ((n == 4'd2) && m.mid[i]);
    end
    return res;
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  // configuration
  logic [10:0] width_q, height_q;
  logic [15:0] patience_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      patience_q <= PATIENCE_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_WIDTH:    width_q    <= cfg_data_i[10:0];
        REG_HEIGHT:   height_q   <= cfg_data_i[10:0];
        REG_PATIENCE: patience_q <= cfg_data_i;
        REG_NONE:     ;
        default:      ;
      endcase
    end
  end

  logic [WB-1:0] w_raw, w_eff, hw_full;
  logic [CW:0]   hw;
  logic [4:0]    msh;
  logic [31:0]   emask;
  logic [HB-1:0] h_raw, h_eff;

  assign w_raw = WB'(width_q);
  always_comb begin
    priority if (w_raw == '0)          w_eff = WB'(1);
    else if (w_raw > WB'(MAXW))        w_eff = WB'(MAXW);
    else                               w_eff = w_raw;
  end
  assign hw_full = (w_eff + WB'(31)) >> 5;
  assign hw      = hw_full[CW:0];
  assign msh     = 5'd31 - w_eff[4:0] + 5'd1;
  assign emask   = 32'hFFFF_FFFF >> msh;

  assign h_raw = HB'(height_q);
  always_comb begin
    priority if (h_raw == '0)          h_eff = HB'(1);
    else if (h_raw > HB'(MAX_ROWS))    h_eff = HB'(MAX_ROWS);
    else                               h_eff = h_raw;
  end

  // input position
  logic [CW-1:0] col_q, cur_c_q, c_eff;
  logic [RW-1:0] row_q, cur_r_q, r_eff;
  logic          last_col_q, last_row_q, lc_now;
  logic [31:0]   word_q, word_m;

  always_comb begin
    c_eff = ({1'b0, col_q} >= hw) ? CW'(hw - 1'b1) : col_q;
    r_eff = (HB'(row_q) >= h_eff) ? RW'(h_eff - 1'b1) : row_q;
  end
  assign lc_now = ((CW + 1)'(c_eff) + 1'b1) == hw;
  assign word_m = lc_now ? (cell_word_i & emask) : cell_word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.col) begin
      if (last_col_q) begin
        col_q <= '0;
        row_q <= last_row_q ? '0 : RW'(cur_r_q + 1'b1);
      end else begin
        col_q <= CW'(cur_c_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_c_q    <= c_eff;
      cur_r_q    <= r_eff;
      last_col_q <= lc_now;
      last_row_q <= (HB'(r_eff) + 1'b1) == h_eff;
      word_q     <= word_m;
    end
  end

  // row RAMs with rotating roles
  logic [1:0]    above_sel_q, mid_sel_q, below_sel_q;
  logic [CW:0]   fl_j_q;
  logic [CW-1:0] raddr;
  logic [31:0]   rdata [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_sel_q <= 2'd0;
      mid_sel_q   <= 2'd1;
      below_sel_q <= 2'd2;
    end else if (cmd_i.col && last_col_q) begin
      above_sel_q <= mid_sel_q;
      mid_sel_q   <= below_sel_q;
      below_sel_q <= above_sel_q;
    end
  end

  assign raddr = cmd_i.fl_read ? fl_j_q[CW-1:0] : c_eff;

  for (genvar b = 0; b < 3; b++) begin : g_bank
    lgld_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ROW_WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.accept && (below_sel_q == 2'(b))),
      .waddr_i (c_eff),
      .wdata_i (word_m),
      .raddr_i (raddr),
      .rdata_o (rdata[b])
    );
  end

  // column window
  col3_t win_c_q, win_r_q, col_new, col_zero;
  logic  up_ok;

  assign up_ok         = cmd_i.flush ? (cur_r_q != '0) : (cur_r_q > RW'(1));
  assign col_new.up    = up_ok ? rdata[above_sel_q] : 32'd0;
  assign col_new.mid   = rdata[mid_sel_q];
  assign col_new.dn    = cmd_i.flush ? 32'd0 : word_q;
  assign col_zero      = '0;

  always_ff @(posedge clk_i) begin
    if ((cmd_i.accept && (c_eff == '0)) || cmd_i.fl_start) begin
      win_c_q <= '0;
      win_r_q <= '0;
    end else if (cmd_i.col || cmd_i.fl_shift) begin
      win_c_q <= win_r_q;
      win_r_q <= col_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_j_q <= '0;
    end else if (cmd_i.fl_start) begin
      fl_j_q <= '0;
    end else if (cmd_i.fl_shift) begin
      fl_j_q <= fl_j_q + 1'b1;
    end
  end

  // result word
  logic [31:0]   res_q, life_w;
  logic [RW-1:0] res_row_q;
  logic [CW-1:0] res_col_q;

  assign life_w = cmd_i.edge_mode ? (life_fn(win_c_q, win_r_q, col_zero) & emask)
                                  : life_fn(win_c_q, win_r_q, col_new);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q     <= life_w;
      res_row_q <= cmd_i.flush ? cur_r_q : RW'(cur_r_q - 1'b1);
      priority if (cmd_i.edge_mode) res_col_q <= cur_c_q;
      else if (cmd_i.flush)         res_col_q <= CW'(fl_j_q - 1'b1);
      else                          res_col_q <= CW'(cur_c_q - 1'b1);
    end
  end

  // CRC, history, patience
  logic [15:0]              crc_q;
  logic [7:0]               crc_in;
  logic [15:0]              hist_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] match_q;
  logic [15:0]              pleft_q, pleft_n;
  logic                     hit, restart;

  always_comb begin
    unique case (cmd_i.crc_byte)
      2'd0:    crc_in = res_q[7:0];
      2'd1:    crc_in = res_q[15:8];
      2'd2:    crc_in = res_q[23:16];
      default: crc_in = res_q[31:24];
    endcase
  end

  assign hit     = |match_q;
  assign pleft_n = hit ? ((pleft_q != '0) ? pleft_q - 16'd1 : 16'd0) : patience_q;
  assign restart = (pleft_n == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      pleft_q <= PATIENCE_RESET;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
    end else if (cmd_i.crc_step) begin
      crc_q <= crc_byte(crc_q, crc_in);
    end else if (cmd_i.put && cmd_i.last) begin
      crc_q   <= '0;
      pleft_q <= restart ? patience_q : pleft_n;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        if (restart)                        hist_q[i] <= '0;
        else if (i == HISTORY_DEPTH - 1)    hist_q[i] <= crc_q;
        else                                hist_q[i] <= hist_q[(i + 1) % HISTORY_DEPTH];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) match_q[i] <= (hist_q[i] == crc_q);
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      next_word_o       <= res_q;
      out_row_o         <= 10'(res_row_q);
      out_col_o         <= 5'(res_col_q);
      gen_last_o        <= cmd_i.last;
      gen_crc_o         <= cmd_i.last ? crc_q : 16'd0;
      loop_hit_o        <= cmd_i.last && hit;
      restart_request_o <= cmd_i.last && restart;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.emit_ok  = (cur_r_q != '0) && (cur_c_q != '0);
  assign stat_o.row_ge1  = (cur_r_q != '0);
  assign stat_o.last_col = last_col_q;
  assign stat_o.last_row = last_row_q;
  assign stat_o.fl_j_ge1 = (fl_j_q != '0);
  assign stat_o.fl_last  = (fl_j_q + 1'b1) == hw;
  assign stat_o.fl_done  = (fl_j_q == hw);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

@@ hdl/lgld_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the Life block, bound to the top level.
// Depends on life_generation_with_loop_detect.
module lgld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] next_word_o,
  input logic        gen_last_o,
  input logic [15:0] gen_crc_o,
  input logic        loop_hit_o,
  input logic        restart_request_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_word_o))
    else $error("stalled output word changed");

  a_gen_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gen_last_o |-> gen_crc_o == 16'd0 && !loop_hit_o && !restart_request_o)
    else $error("generation fields set on an inner word");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while word in flight");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word appeared while idle");

endmodule

bind life_generation_with_loop_detect lgld_checker u_lgld_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .next_word_o       (next_word_o),
  .gen_last_o        (gen_last_o),
  .gen_crc_o         (gen_crc_o),
  .loop_hit_o        (loop_hit_o),
  .restart_request_o (restart_request_o)
);

@@ verif/life_generation_with_loop_detect_checker.sv @@
`timescale 1ns / 1ps
// Checker for life_generation_with_loop_detect: predicts the next-generation words,
// CRC, history hit and restart flags and compares them with the output channel.
// Depends on lgld_pkg.
module life_generation_with_loop_detect_checker
  import lgld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] cell_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] next_word_i,
  input  logic [9:0]  out_row_i,
  input  logic [4:0]  out_col_i,
  input  logic        gen_last_i,
  input  logic [15:0] gen_crc_i,
  input  logic        loop_hit_i,
  input  logic        restart_request_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0] cells;
    logic [9:0]  row;
    logic [4:0]  col;
    logic        last;
    logic [15:0] crc;
    logic        hit;
    logic        restart;
  } gen_word_t;

  typedef logic [31:0] row_buf_t [MAX_ROW_WORDS_DEF];

  gen_word_t   gen_q[$];
  logic [10:0] width_r, height_r;
  logic [15:0] patience_r, patience_left;
  row_buf_t    row_up, row_mid, row_dn;
  int          col_cnt, row_cnt;
  logic [15:0] crc_acc;
  logic [15:0] crc_hist [HISTORY_DEPTH_DEF];

  assign pending_o = gen_q.size();

  function automatic int grid_width();
    int w;
    w = width_r;
    if (w == 0) w = 1;
    if (w > MAX_ROW_WORDS_DEF * 32) w = MAX_ROW_WORDS_DEF * 32;
    return w;
  endfunction

  function automatic int grid_height();
    int h;
    h = height_r;
    if (h == 0) h = 1;
    if (h > MAX_ROWS_DEF) h = MAX_ROWS_DEF;
    return h;
  endfunction

  function automatic logic [31:0] right_mask();
    return 32'hFFFF_FFFF >> (31 - ((grid_width() - 1) & 31));
  endfunction

  function automatic logic [31:0] pick(input row_buf_t rows, input bit ok, input int c,
                                       input int hw);
    if (!ok || c < 0 || c >= hw) return '0;
    return rows[c];
  endfunction

  function automatic logic [31:0] next_cells(input row_buf_t up, input bit up_ok,
                                             input row_buf_t mid, input row_buf_t dn,
                                             input bit dn_ok, input int c);
    int hw, n;
    logic [31:0] u, m, d, res;
    logic [31:0] nb [8];
    hw = (grid_width() + 31) >> 5;
    u = pick(up, up_ok, c, hw);
    m = pick(mid, 1'b1, c, hw);
    d = pick(dn, dn_ok, c, hw);
    nb[0] = (u << 1) | (pick(up, up_ok, c - 1, hw) >> 31);
    nb[1] = u;
    nb[2] = (u >> 1) | (pick(up, up_ok, c + 1, hw) << 31);
    nb[3] = (m << 1) | (pick(mid, 1'b1, c - 1, hw) >> 31);
    nb[4] = (m >> 1) | (pick(mid, 1'b1, c + 1, hw) << 31);
    nb[5] = (d << 1) | (pick(dn, dn_ok, c - 1, hw) >> 31);
    nb[6] = d;
    nb[7] = (d >> 1) | (pick(dn, dn_ok, c + 1, hw) << 31);
    res = '0;
    for (int i = 0; i < 32; i++) begin
      n = 0;
      for (int k = 0; k < 8; k++) n += nb[k][i];
      res[i] = (n == 3) || (n == 2 && m[i]);
    end
    if (c + 1 >= hw) res &= right_mask();
    return res;
  endfunction

  task automatic push_word(input int r, input int c, input bit up_ok, input bit dn_ok);
    gen_word_t g;
    g.cells = next_cells(row_up, up_ok, row_mid, row_dn, dn_ok, c);
    g.row = r[9:0];
    g.col = c[4:0];
    g.last = 1'b0;
    g.crc = '0;
    g.hit = 1'b0;
    g.restart = 1'b0;
    for (int b = 0; b < 4; b++) begin
      crc_acc ^= {8'h00, g.cells[8*b +: 8]};
      for (int k = 0; k < 8; k++)
        crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
    end
    gen_q.push_back(g);
  endtask

  task automatic close_generation();
    bit hit, rs;
    int t;
    hit = 1'b0;
    rs = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH_DEF; i++) begin
      if (crc_hist[i] == crc_acc) hit = 1'b1;
      crc_hist[i] = (i == HISTORY_DEPTH_DEF - 1) ? crc_acc : crc_hist[i + 1];
    end
    if (hit) begin
      if (patience_left != 0) patience_left--;
    end else begin
      patience_left = patience_r;
    end
    if (patience_left == 0) begin
      rs = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH_DEF; i++) crc_hist[i] = '0;
      patience_left = patience_r;
    end
    t = gen_q.size() - 1;
    gen_q[t].last = 1'b1;
    gen_q[t].crc = crc_acc;
    gen_q[t].hit = hit;
    gen_q[t].restart = rs;
    crc_acc = '0;
  endtask

  task automatic take_word(input logic [31:0] w);
    int hw, h, c, r;
    bit lc, lr;
    hw = (grid_width() + 31) >> 5;
    h = grid_height();
    c = (col_cnt >= hw) ? hw - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    lc = (c + 1 == hw);
    lr = (r + 1 == h);
    if (lc) w &= right_mask();
    row_dn[c] = w;
    if (r >= 1) begin
      if (c >= 1) push_word(r - 1, c - 1, r >= 2, 1'b1);
      if (lc) push_word(r - 1, c, r >= 2, 1'b1);
    end
    if (!lc) begin
      col_cnt = c + 1;
      row_cnt = r;
    end else begin
      row_up = row_mid;
      row_mid = row_dn;
      col_cnt = 0;
      if (!lr) begin
        row_cnt = r + 1;
      end else begin
        for (int j = 0; j < hw; j++) push_word(r, j, r >= 1, 1'b0);
        close_generation();
        row_cnt = 0;
      end
    end
  endtask

  task automatic compare_word();
    gen_word_t g;
    if (gen_q.size() == 0) begin
      $display("%0t: unexpected word %h row %0d col %0d", $time, next_word_i, out_row_i,
               out_col_i);
      fail_count_o++;
    end else begin
      g = gen_q.pop_front();
      if (next_word_i !== g.cells || out_row_i !== g.row || out_col_i !== g.col ||
          gen_last_i !== g.last || gen_crc_i !== g.crc || loop_hit_i !== g.hit ||
          restart_request_i !== g.restart) begin
        $display("%0t: mismatch expected word %h row %0d col %0d last %b crc %h hit %b rs %b",
                 $time, g.cells, g.row, g.col, g.last, g.crc, g.hit, g.restart);
        $display("%0t:          actual word %h row %0d col %0d last %b crc %h hit %b rs %b",
                 $time, next_word_i, out_row_i, out_col_i, gen_last_i, gen_crc_i,
                 loop_hit_i, restart_request_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q.delete();
      width_r = WIDTH_RESET;
      height_r = HEIGHT_RESET;
      patience_r = PATIENCE_RESET;
      patience_left = PATIENCE_RESET;
      col_cnt = 0;
      row_cnt = 0;
      crc_acc = '0;
      fail_count_o = 0;
      for (int i = 0; i < MAX_ROW_WORDS_DEF; i++) begin
        row_up[i] = '0;
        row_mid[i] = '0;
        row_dn[i] = '0;
      end
      for (int i = 0; i < HISTORY_DEPTH_DEF; i++) crc_hist[i] = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_WIDTH:    width_r = cfg_data_i[10:0];
          REG_HEIGHT:   height_r = cfg_data_i[10:0];
          REG_PATIENCE: patience_r = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_word(cell_word_i);
      if (out_valid_i && !out_stall_i) compare_word();
    end
  end

endmodule

@@ verif/life_generation_with_loop_detect_test.sv @@
`timescale 1ns / 1ps
// Testbench top for life_generation_with_loop_detect: drives whole frames under
// varied grid settings and random gaps; depends on lgld_pkg and the checker module.
module life_generation_with_loop_detect_test;
  import lgld_pkg::*;

  typedef enum int {FR_RANDOM, FR_REPEAT, FR_SPARSE, FR_SOLID} frame_kind_e;

  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [31:0] cell_word = '0;
  logic        out_stall = 1'b0;
  logic        cfg_ready, in_stall, out_valid, gen_last, loop_hit, restart_request;
  logic [31:0] next_word;
  logic [9:0]  out_row;
  logic [4:0]  out_col;
  logic [15:0] gen_crc;
  int          fail_count, pending, idle_cycles = 0, words_sent = 0;
  int          stall_left = 0, run_left = 0;
  bit          calm = 1'b0;

  always #2 clk = ~clk;

  life_generation_with_loop_detect uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cell_word_i(cell_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .next_word_o(next_word),
    .out_row_o(out_row), .out_col_o(out_col), .gen_last_o(gen_last), .gen_crc_o(gen_crc),
    .loop_hit_o(loop_hit), .restart_request_o(restart_request)
  );

  life_generation_with_loop_detect_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cell_word_i(cell_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .next_word_i(next_word),
    .out_row_i(out_row), .out_col_i(out_col), .gen_last_i(gen_last), .gen_crc_i(gen_crc),
    .loop_hit_i(loop_hit), .restart_request_i(restart_request),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver back-pressure: alternating runs and stalls
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left <= run_left - 1;
    end else begin
      out_stall <= 1'b0;
      run_left <= $urandom_range(0, 20);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
                    $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL life_generation_with_loop_detect");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_regs(input logic [15:0] w, input logic [15:0] h, input logic [15:0] p);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= (i == 0) ? REG_WIDTH : (i == 1) ? REG_HEIGHT : REG_PATIENCE;
      cfg_data <= (i == 0) ? w : (i == 1) ? h : p;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input logic [15:0] w, input logic [15:0] h, input logic [15:0] p,
                            input int frames, input frame_kind_e kind);
    int ew, eh, n;
    logic [31:0] frame[];
    write_regs(w, h, p);
    calm = ($urandom_range(0, 3) == 0);
    ew = int'(w[10:0]);
    eh = int'(h[10:0]);
    if (ew == 0) ew = 1;
    if (ew > MAX_ROW_WORDS_DEF * 32) ew = MAX_ROW_WORDS_DEF * 32;
    if (eh == 0) eh = 1;
    if (eh > MAX_ROWS_DEF) eh = MAX_ROWS_DEF;
    n = ((ew + 31) >> 5) * eh;
    frame = new[n];
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < n; i++) begin
        case (kind)
          FR_RANDOM: frame[i] = $urandom;
          FR_REPEAT: if (f == 0) frame[i] = $urandom;
          FR_SPARSE: frame[i] = $urandom & $urandom & $urandom;
          default:   frame[i] = f[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
      end
      for (int i = 0; i < n; i++) send_word(frame[i]);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_frames(16'd1, 16'd1, 16'd1, 4, FR_SOLID);
    run_frames(16'd0, 16'd0, 16'd2, 3, FR_SOLID);
    run_frames(16'd33, 16'd2, 16'd3, 3, FR_REPEAT);
    run_frames(16'hFFFF, 16'd1, 16'd0, 1, FR_RANDOM);
    run_frames(16'd1024, 16'd2, 16'hFFFF, 1, FR_SOLID);
    run_frames(16'd1024, 16'd1024, 16'd1, 0, FR_RANDOM);
    while (words_sent < 400)
      run_frames(16'($urandom_range(1, 100)), 16'($urandom_range(1, 5)),
                 16'($urandom_range(0, 3)), $urandom_range(1, 4),
                 frame_kind_e'($urandom_range(0, 3)));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("PASS life_generation_with_loop_detect");
    else
      $display("FAIL life_generation_with_loop_detect");
    $finish;
  end

endmodule

@@ life_generation_with_loop_detect.f @@
hdl/lgld_pkg.sv
hdl/lgld_ram.sv
hdl/lgld_ctrl.sv
hdl/lgld_dp.sv
hdl/life_generation_with_loop_detect.sv
hdl/lgld_checker.sv
verif/life_generation_with_loop_detect_checker.sv
verif/life_generation_with_loop_detect_test.sv
